[src/u8d_pkg.sv]
// u8d_pkg: shared types and constants for the streaming utf-8 decoder
// result kinds, error codes, decoder state and the per-request result bundle
// no dependencies
package u8d_pkg;

  localparam int unsigned MaxResults = 3;

  localparam logic [20:0] MaxScalar     = 21'h10FFFF;
  localparam logic [7:0]  SurrogateLead = 8'hED;
  localparam logic [10:0] LeadSurrPage  = 11'h036;  // 0xd800..0xdbff >> 10
  localparam logic [10:0] TrailSurrPage = 11'h037;  // 0xdc00..0xdfff >> 10
  localparam logic [5:0]  SurrHigh      = 6'b110110;

  typedef enum logic [1:0] {
    KIND_CP  = 2'd0,
    KIND_ERR = 2'd1,
    KIND_END = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ERR_NONE         = 3'd0,
    ERR_INVALID_UNIT = 3'd1,
    ERR_INVALID_CP   = 3'd2,
    ERR_PAIRED_SURR  = 3'd3,
    ERR_UNEXP_CONT   = 3'd4,
    ERR_UNEXP_START  = 3'd5,
    ERR_UNEXP_EOF    = 3'd6
  } err_t;

  typedef struct packed {
    kind_t       kind;
    logic [20:0] scalar_value;
    err_t        error_code;
  } result_t;

  typedef struct packed {
    result_t [MaxResults-1:0] res;
    logic [1:0]               cnt;
  } bundle_t;

  typedef struct packed {
    logic [1:0]  bytes_needed;
    logic [1:0]  bytes_seen;
    logic [20:0] accumulator;
    err_t        held_error;
    logic        stopped;
    logic        pending_valid;
    logic [9:0]  pending_surrogate;
  } dec_state_t;

  function automatic result_t mk_result(kind_t k, logic [20:0] cp, err_t e);
    result_t r;
    r.kind         = k;
    r.scalar_value = cp;
    r.error_code   = e;
    return r;
  endfunction

  function automatic err_t follower_check(logic [7:0] b);
    err_t e;
    if (b[7:6] == 2'b10) begin
      e = ERR_NONE;
    end else if (b >= 8'hF8) begin
      e = ERR_INVALID_UNIT;
    end else begin
      e = ERR_UNEXP_START;
    end
    return e;
  endfunction

endpackage

[src/u8d_step.sv]
// u8d_step: decoder state registers and the single-pass decode of one request
// produces up to three results per request as a bundle
// depends on u8d_pkg
module u8d_step (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_fire,
  input  logic [7:0]       data_byte,
  input  logic             is_end,
  output u8d_pkg::bundle_t bundle
);
  import u8d_pkg::*;

  dec_state_t st;
  dec_state_t st_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (in_fire) begin
      st <= st_next;
    end
  end

  always_comb begin
    result_t [MaxResults-1:0] res;
    logic [1:0]  cnt;
    logic [20:0] acc_n;
    logic [20:0] held_cp;
    err_t        herr_n;
    err_t        fe;

    res     = '0;
    cnt     = '0;
    st_next = st;
    acc_n   = {st.accumulator[14:0], data_byte[5:0]};
    held_cp = {5'd0, SurrHigh, st.pending_surrogate};
    fe      = follower_check(data_byte);
    herr_n  = (st.held_error == ERR_NONE) ? fe : st.held_error;

    if (is_end) begin
      if (!st.stopped && st.pending_valid) begin
        res[cnt] = mk_result(KIND_CP, held_cp, ERR_NONE);
        cnt = cnt + 2'd1;
      end
      if (!st.stopped && st.bytes_needed != 2'd0) begin
        res[cnt] = mk_result(KIND_ERR, '0, ERR_UNEXP_EOF);
        cnt = cnt + 2'd1;
      end
      res[cnt] = mk_result(KIND_END, '0, ERR_NONE);
      cnt = cnt + 2'd1;
      st_next = '0;
    end else if (st.stopped) begin
      st_next = st;
    end else if (st.bytes_needed != 2'd0) begin
      // follower byte
      st_next.accumulator  = acc_n;
      st_next.held_error   = herr_n;
      st_next.bytes_needed = st.bytes_needed - 2'd1;
      if (st.bytes_needed == 2'd1) begin
        if (herr_n != ERR_NONE ||
            (st.bytes_seen == 2'd3 && acc_n > MaxScalar)) begin
          if (st.pending_valid) begin
            res[cnt] = mk_result(KIND_CP, held_cp, ERR_NONE);
            cnt = cnt + 2'd1;
          end
          res[cnt] = mk_result(KIND_ERR, '0,
                               (herr_n != ERR_NONE) ? herr_n : ERR_INVALID_CP);
          cnt = cnt + 2'd1;
          st_next.stopped           = 1'b1;
          st_next.bytes_seen        = '0;
          st_next.held_error        = ERR_NONE;
          st_next.pending_valid     = 1'b0;
          st_next.pending_surrogate = '0;
        end else if (st.pending_valid && acc_n[20:10] == TrailSurrPage) begin
          // a surrogate pair encoded as two 3-byte forms
          res[cnt] = mk_result(KIND_ERR, '0, ERR_PAIRED_SURR);
          cnt = cnt + 2'd1;
          st_next.stopped           = 1'b1;
          st_next.bytes_seen        = '0;
          st_next.held_error        = ERR_NONE;
          st_next.pending_valid     = 1'b0;
          st_next.pending_surrogate = '0;
        end else begin
          if (st.pending_valid) begin
            res[cnt] = mk_result(KIND_CP, held_cp, ERR_NONE);
            cnt = cnt + 2'd1;
          end
          st_next.pending_valid     = 1'b0;
          st_next.pending_surrogate = '0;
          if (st.bytes_seen == 2'd2 && acc_n[20:10] == LeadSurrPage) begin
            st_next.pending_valid     = 1'b1;
            st_next.pending_surrogate = acc_n[9:0];
          end else begin
            res[cnt] = mk_result(KIND_CP, acc_n, ERR_NONE);
            cnt = cnt + 2'd1;
          end
          st_next.bytes_seen = '0;
        end
      end
    end else begin
      // lead byte
      if (st.pending_valid && data_byte != SurrogateLead) begin
        res[cnt] = mk_result(KIND_CP, held_cp, ERR_NONE);
        cnt = cnt + 2'd1;
        st_next.pending_valid     = 1'b0;
        st_next.pending_surrogate = '0;
      end
      st_next.held_error = ERR_NONE;
      priority if (data_byte < 8'h80) begin
        res[cnt] = mk_result(KIND_CP, {13'd0, data_byte}, ERR_NONE);
        cnt = cnt + 2'd1;
      end else if (data_byte < 8'hC0) begin
        res[cnt] = mk_result(KIND_ERR, '0, ERR_UNEXP_CONT);
        cnt = cnt + 2'd1;
        st_next.stopped = 1'b1;
      end else if (data_byte < 8'hE0) begin
        st_next.bytes_needed = 2'd1;
        st_next.bytes_seen   = 2'd1;
        st_next.accumulator  = {16'd0, data_byte[4:0]};
      end else if (data_byte < 8'hF0) begin
        st_next.bytes_needed = 2'd2;
        st_next.bytes_seen   = 2'd2;
        st_next.accumulator  = {17'd0, data_byte[3:0]};
      end else if (data_byte < 8'hF8) begin
        st_next.bytes_needed = 2'd3;
        st_next.bytes_seen   = 2'd3;
        st_next.accumulator  = {18'd0, data_byte[2:0]};
      end else begin
        res[cnt] = mk_result(KIND_ERR, '0, ERR_INVALID_UNIT);
        cnt = cnt + 2'd1;
        st_next.stopped = 1'b1;
      end
    end

    bundle.res = res;
    bundle.cnt = cnt;
  end

endmodule

[src/u8d_serializer.sv]
// u8d_serializer: result register holding one request's bundle
// hands the results out one per cycle while out_ready is high and marks the last one
// depends on u8d_pkg
module u8d_serializer (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_fire,
  input  u8d_pkg::bundle_t bundle,
  output logic             take_ok,
  output logic             out_valid,
  input  logic             out_ready,
  output u8d_pkg::result_t result,
  output logic             last_of_run
);
  import u8d_pkg::*;

  result_t [MaxResults-1:0] res_q;
  logic [1:0] cnt;
  logic [1:0] idx;
  logic       at_last;
  logic       out_fire;

  assign out_valid   = (cnt != 2'd0);
  assign at_last     = (idx + 2'd1 == cnt);
  assign out_fire    = out_valid && out_ready;
  assign last_of_run = at_last;
  assign result      = res_q[idx];
  // a new request may enter when the register is empty or its last buffered result leaves this cycle
  assign take_ok     = !out_valid || (out_ready && at_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      idx <= '0;
    end else if (in_fire) begin
      cnt <= bundle.cnt;
      idx <= '0;
    end else if (out_fire) begin
      if (at_last) begin
        cnt <= '0;
        idx <= '0;
      end else begin
        idx <= idx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      res_q <= bundle.res;
    end
  end

endmodule

[src/utf8_decoder_stream.sv]
// utf8_decoder_stream: streaming utf-8 decoder, top level
// depends on u8d_pkg, u8d_step, u8d_serializer
//
// input channel: in_valid/in_ready with data_byte and is_end; each request is
// one byte of a string, or an end mark (is_end high) closing the string.
// output channel: out_valid/out_ready with kind, scalar_value, error_code and
// last_of_run; a request gives zero to three results, last_of_run marking
// the final result of a request.
// latency: the first result of a request is shown the cycle after the
// request is accepted; later results follow one per cycle while out_ready is high.
// throughput: one request per cycle while each request gives at most one
// result and the receiver takes every cycle; a request with several results
// holds off the next request until its last result is being taken, as there
// is a single result register; a request that gives no result leaves in_ready high.
// reset: clears the decoder state and drops any results not yet taken.
// receiver stall: the current result holds, and in_ready stays low until
// the last result of the buffered request is being taken.
module utf8_decoder_stream (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        is_end,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  kind,
  output logic [20:0] scalar_value,
  output logic [2:0]  error_code,
  output logic        last_of_run
);
  import u8d_pkg::*;

  bundle_t bundle;
  result_t result;
  logic    in_fire;

  assign in_fire = in_valid && in_ready;

  u8d_step u_step (
    .clk       (clk),
    .rst       (rst),
    .in_fire   (in_fire),
    .data_byte (data_byte),
    .is_end    (is_end),
    .bundle    (bundle)
  );

  u8d_serializer u_ser (
    .clk         (clk),
    .rst         (rst),
    .in_fire     (in_fire),
    .bundle      (bundle),
    .take_ok     (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .result      (result),
    .last_of_run (last_of_run)
  );

  assign kind         = result.kind;
  assign scalar_value = result.scalar_value;
  assign error_code   = result.error_code;

endmodule

[src/u8d_checker.sv]
// u8d_checker: port-level checks for utf8_decoder_stream
// bound to the top level; depends on u8d_pkg
module u8d_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  kind,
  input logic [20:0] scalar_value,
  input logic [2:0]  error_code,
  input logic        last_of_run
);
  import u8d_pkg::*;

  // a stalled result holds its fields
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(kind) &&
      $stable(scalar_value) && $stable(error_code) && $stable(last_of_run))
    else $error("stalled result changed");

  // nothing is shown right after reset
  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result shown after reset");

  // an end of string always closes its request
  a_end_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == KIND_END |-> last_of_run && scalar_value == '0 &&
      error_code == ERR_NONE)
    else $error("end result malformed");

  // errors carry a code and no value, code points carry no code
  a_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid |->
      (kind == KIND_ERR && scalar_value == '0 && error_code != ERR_NONE) ||
      (kind == KIND_CP && error_code == ERR_NONE && scalar_value <= MaxScalar) ||
      kind == KIND_END)
    else $error("result fields inconsistent");

endmodule

bind utf8_decoder_stream u8d_checker u_chk (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .kind         (kind),
  .scalar_value (scalar_value),
  .error_code   (error_code),
  .last_of_run  (last_of_run)
);
